// ===== hw/rtl/circular_deque_core_macros.svh =====
// ----------------------------------------------------------------------------
// circular_deque_core_macros.svh
// Assertion macros for the deque top level.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define CDQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// ===== hw/rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Constants, codes and types shared by the deque cell row and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes
  typedef enum logic [1:0] {
    KIND_PUSH_REAR  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_in;   // push front: row shifts toward the rear
    logic shift_out;  // pop front: row shifts toward the front
    logic append;     // push rear: first empty cell takes the word
    logic drop;       // pop rear: last occupied cell empties
  } cdq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One position of the deque row: a word and its valid flag, loaded from the
// neighbor on either side or from the push word.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cdq_pkg::cdq_cmd_t           cmd,
  input  wire logic signed [31:0]          push_value,
  input  wire logic                        left_valid,
  input  wire logic signed [31:0]          left_data,
  input  wire logic                        right_valid,
  input  wire logic signed [31:0]          right_data,
  output logic                             valid,
  output logic signed [31:0]               data,
  output logic signed [31:0]               tail_data
);

  import cdq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic signed [WORD_W-1:0] data_r, data_nxt;

  // Next state from the broadcast command
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (cmd.shift_in) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (cmd.shift_out) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (cmd.append && left_valid && !valid_r) begin
      valid_nxt = 1'b1;
      data_nxt  = push_value;
    end else if (cmd.drop && valid_r && !right_valid) begin
      valid_nxt = 1'b0;
    end
  end

  // Valid flag: control state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Word: payload, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid     = valid_r;
  assign data      = data_r;
  // Rear word shows only from the last occupied cell
  assign tail_data = (valid_r && !right_valid) ? data_r : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_core.sv =====
// A result word strobes in the cycle after its command is taken.
// Throughput: one command per cycle; busy stays low, as every operation
// completes in a single load of the cell row.
// Reset (rst_n low, synchronous): all cells empty, occupancy zero.
// Results cannot be stalled by the receiver: out_strobe lasts one cycle.
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue built as a row of cells, front at cell 0, with status,
// popped word and occupancy reported per command.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_kind,
  input  wire logic signed [31:0]           in_push_value,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic signed [31:0]                out_removed_value,
  output logic [cdq_pkg::CNT_W-1:0]         out_occupancy
);

  import cdq_pkg::*;

`include "circular_deque_core_macros.svh"

  logic                     accept;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     full, empty;
  cdq_cmd_t                 cmd;
  status_t                  status_nxt;
  logic signed [WORD_W-1:0] removed_nxt;
  logic signed [WORD_W-1:0] tail_word;

  logic [CAPACITY-1:0]      valid_vec;
  logic signed [WORD_W-1:0] data_vec [CAPACITY];
  logic signed [WORD_W-1:0] tail_vec [CAPACITY];

  logic                     out_strobe_r;
  status_t                  out_status_r;
  logic signed [WORD_W-1:0] out_removed_r;
  logic [CNT_W-1:0]         out_occupancy_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);

  // Rear word: one-hot OR over the cells
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_word = tail_word | tail_vec[i];
    end
  end

  // Command decode, status and count update
  always_comb begin
    cmd         = '0;
    status_nxt  = ST_DONE;
    removed_nxt = '0;
    count_nxt   = count_r;
    case (kind_t'(in_kind))
      KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.append = accept;
          count_nxt  = count_r + 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.shift_in = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.shift_out = accept;
          removed_nxt   = data_vec[0];
          count_nxt     = count_r - 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd.drop    = accept;
          removed_nxt = tail_word;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Cell row: cell 0 sees the push word on its left, the last cell an empty
  // slot on its right
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     lv, rv;
    logic signed [WORD_W-1:0] ld, rd;

    if (g == 0) begin : g_head
      assign lv = 1'b1;
      assign ld = in_push_value;
    end else begin : g_mid_l
      assign lv = valid_vec[g-1];
      assign ld = data_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = valid_vec[g+1];
      assign rd = data_vec[g+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_value  (in_push_value),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (valid_vec[g]),
      .data        (data_vec[g]),
      .tail_data   (tail_vec[g])
    );
  end

  // Occupancy count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_removed_r   <= removed_nxt;
      out_occupancy_r <= count_nxt;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_occupancy     = out_occupancy_r;

  // Occupied cells form a solid run from the front
  `CDQ_ASSERT_IMPLY(a_packed_row, 1'b1, (((valid_vec >> 1) & ~valid_vec) == '0))
  // Count tracks the occupied cells
  `CDQ_ASSERT_IMPLY(a_count_match, 1'b1, ($countones(valid_vec) == int'(count_r)))
  // One result per accepted command, in the cycle after it
  `CDQ_ASSERT_NEXT(a_strobe_follows, accept, out_strobe)
  `CDQ_ASSERT_NEXT(a_no_spurious, !accept, !out_strobe)
  // Rejected pushes report a full store and no word
  `CDQ_ASSERT_IMPLY(a_full_reject, (out_strobe && out_status == ST_FULL),
                    (out_occupancy == CNT_W'(CAPACITY) && out_removed_value == '0))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for circular_deque_core: a scoreboard tracks the deque
// contents and predicts status, popped word and occupancy for every command;
// directed corner cases come first, then biased random traffic under
// several sender idling phases.
// ----------------------------------------------------------------------------

import cdq_pkg::*;

// One expected reply word
typedef struct {
  status_t                    status;
  logic signed [WORD_W-1:0]   removed;
  logic [CNT_W-1:0]           occupancy;
} deque_reply_t;

// Tracks deque contents and the replies still owed by the block
class deque_scoreboard;
  logic signed [WORD_W-1:0] store [CAPACITY];
  int                       head_idx;
  int                       tail_idx;
  int                       held;
  deque_reply_t             replies_due [$];
  int                       mismatches;

  function new();
    head_idx   = 0;
    tail_idx   = 0;
    held       = 0;
    mismatches = 0;
  endfunction

  function int next_slot(int i);
    return (i >= CAPACITY - 1) ? 0 : i + 1;
  endfunction

  function int prev_slot(int i);
    return (i == 0) ? CAPACITY - 1 : i - 1;
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // Apply one accepted command and queue the reply it must produce
  function void note_command(kind_t k, logic signed [WORD_W-1:0] v);
    deque_reply_t r;
    r.status  = ST_DONE;
    r.removed = '0;
    if (k == KIND_PUSH_REAR || k == KIND_PUSH_FRONT) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        if (held == 0) begin
          // first word always lands in slot 0
          head_idx = 0;
          tail_idx = 0;
          store[0] = v;
        end else if (k == KIND_PUSH_REAR) begin
          tail_idx = next_slot(tail_idx);
          store[tail_idx] = v;
        end else begin
          head_idx = prev_slot(head_idx);
          store[head_idx] = v;
        end
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (k == KIND_POP_FRONT) begin
          r.removed = store[head_idx];
          head_idx  = next_slot(head_idx);
        end else begin
          r.removed = store[tail_idx];
          tail_idx  = prev_slot(tail_idx);
        end
        held--;
        // last word gone: indices snap back to 0
        if (held == 0) begin
          head_idx = 0;
          tail_idx = 0;
        end
      end
    end
    r.occupancy = CNT_W'(held);
    replies_due.push_back(r);
  endfunction

  // Compare one reply word against the oldest prediction
  function void check_reply(logic [1:0] st, logic signed [WORD_W-1:0] rv,
                            logic [CNT_W-1:0] occ);
    deque_reply_t e;
    if (replies_due.size() == 0) begin
      $error("reply with no command outstanding: status %0d removed %0d occupancy %0d",
             st, rv, occ);
      mismatches++;
      return;
    end
    e = replies_due.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, st);
      mismatches++;
    end
    if (rv !== e.removed) begin
      $error("removed_value: expected %0d, actual %0d", e.removed, rv);
      mismatches++;
    end
    if (occ !== e.occupancy) begin
      $error("occupancy: expected %0d, actual %0d", e.occupancy, occ);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASE_WORDS  = 437;
  localparam int BIAS_SPAN    = 32;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       start         = 1'b0;
  logic [1:0]                 in_kind       = KIND_PUSH_REAR;
  logic signed [WORD_W-1:0]   in_push_value = '0;
  logic                       busy;
  logic                       out_strobe;
  logic [1:0]                 out_status;
  logic signed [WORD_W-1:0]   out_removed_value;
  logic [CNT_W-1:0]           out_occupancy;

  deque_scoreboard            sb = new();
  int                         sender_idle_pct = 0;
  int unsigned                cycle_count = 0;

  circular_deque_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_push_value     (in_push_value),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_occupancy     (out_occupancy)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_deque_core: mismatch");
      $finish;
    end
  end

  // Reply monitor: the strobe lasts one cycle, taken at the closing edge
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_reply(out_status, out_removed_value, out_occupancy);
  end

  // Issue one command word, with random idle cycles ahead of it
  task automatic send_word(kind_t k, logic signed [WORD_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= k;
    in_push_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_command(k, v);
  endtask

  // Hold off until every outstanding reply has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic: push/pop mix drifts so the deque swings full and empty
  task automatic random_phase(int idle_pct);
    int push_bias;
    kind_t k;
    sender_idle_pct = idle_pct;
    push_bias = 50;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i % BIAS_SPAN == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 85;
          1:       push_bias = 50;
          default: push_bias = 15;
        endcase
      end
      if ($urandom_range(99) < push_bias)
        k = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
      else
        k = $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
      send_word(k, pick_word());
    end
    drain();
  endtask

  // Main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, extreme words, last-word pop, fill to a
    // wrapped full deque, rejected pushes
    sender_idle_pct = 0;
    send_word(KIND_POP_FRONT, 32'sh1234_5678);
    send_word(KIND_POP_REAR, $urandom);
    send_word(KIND_PUSH_REAR, 32'sh7fff_ffff);
    send_word(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_word(KIND_POP_REAR, $urandom);
    send_word(KIND_POP_FRONT, $urandom);
    send_word(KIND_PUSH_FRONT, '0);
    send_word(KIND_PUSH_REAR, -32'sd1);
    for (int i = 0; i < CAPACITY - 2; i++)
      send_word((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_REAR, $urandom);
    send_word(KIND_PUSH_REAR, $urandom);
    send_word(KIND_PUSH_FRONT, $urandom);
    send_word(KIND_POP_FRONT, $urandom);
    drain();

    // Random: no idling, heavy idling, no idling again, light idling
    random_phase(0);
    random_phase(63);
    random_phase(0);
    random_phase(27);

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("circular_deque_core: match");
    else
      $display("circular_deque_core: mismatch");
    $finish;
  end

endmodule
